### rtl/vsd_pkg.sv
package vsd_pkg;

    // Value kinds, same encoding on s_cmd and m_kind
    localparam logic [1:0] KIND_INT32   = 2'd0;
    localparam logic [1:0] KIND_SHORT16 = 2'd1;
    localparam logic [1:0] KIND_LONG64  = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam int PAYLOAD_W = 7;
    localparam int COUNT_W   = 4;
    localparam int VALUE_W   = 64;

    // What the back end does with one byte
    typedef enum logic [1:0] {
        OP_ACC,   // gather payload, no result
        OP_DONE,  // gather payload and emit the finished value
        OP_ERR    // byte limit reached with continuation set
    } vsd_op_t;

    // One classified byte, front to back
    typedef struct packed {
        vsd_op_t                op;
        logic [1:0]             kind;
        logic [COUNT_W-1:0]     idx;
        logic [PAYLOAD_W-1:0]   payload;
    } vsd_entry_t;

    // Byte limit of each kind
    function automatic logic [COUNT_W-1:0] kind_limit(input logic [1:0] k);
        case (k)
            KIND_SHORT16: kind_limit = 4'd3;
            KIND_LONG64:  kind_limit = 4'd10;
            default:      kind_limit = 4'd5;
        endcase
    endfunction

    // Result mask of each kind
    function automatic logic [VALUE_W-1:0] kind_mask(input logic [1:0] k);
        case (k)
            KIND_SHORT16: kind_mask = 64'h0000_0000_0000_FFFF;
            KIND_LONG64:  kind_mask = 64'hFFFF_FFFF_FFFF_FFFF;
            default:      kind_mask = 64'h0000_0000_FFFF_FFFF;
        endcase
    endfunction

    // Bit position of a byte's payload: 7 * index
    function automatic logic [5:0] byte_shift(input logic [COUNT_W-1:0] idx);
        case (idx)
            4'd0:    byte_shift = 6'd0;
            4'd1:    byte_shift = 6'd7;
            4'd2:    byte_shift = 6'd14;
            4'd3:    byte_shift = 6'd21;
            4'd4:    byte_shift = 6'd28;
            4'd5:    byte_shift = 6'd35;
            4'd6:    byte_shift = 6'd42;
            4'd7:    byte_shift = 6'd49;
            4'd8:    byte_shift = 6'd56;
            4'd9:    byte_shift = 6'd63;
            default: byte_shift = 6'd0;
        endcase
    endfunction

endpackage

### rtl/vsd_front.sv
module vsd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [7:0]           s_data_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output vsd_pkg::vsd_entry_t  push_entry
);
    import vsd_pkg::*;

    logic               in_value_reg, in_value_next;
    logic [1:0]         kind_reg, kind_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [1:0]         kind_cur;
    logic [COUNT_W-1:0] idx_cur;
    logic [COUNT_W-1:0] count_inc;
    logic               more;
    logic               accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // Classify the byte against the value in progress
    always_comb begin
        if (in_value_reg) begin
            kind_cur = kind_reg;
            idx_cur  = count_reg;
        end else begin
            kind_cur = (s_cmd == KIND_UNUSED) ? KIND_INT32 : s_cmd;
            idx_cur  = '0;
        end
        more      = s_data_byte[7];
        count_inc = idx_cur + 4'd1;

        push_entry.kind    = kind_cur;
        push_entry.idx     = idx_cur;
        push_entry.payload = s_data_byte[PAYLOAD_W-1:0];
        if (!more) begin
            push_entry.op = OP_DONE;
        end else if (count_inc >= kind_limit(kind_cur)) begin
            push_entry.op = OP_ERR;
        end else begin
            push_entry.op = OP_ACC;
        end

        in_value_next = in_value_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        if (accept) begin
            kind_next = kind_cur;
            if (push_entry.op == OP_ACC) begin
                in_value_next = 1'b1;
                count_next    = count_inc;
            end else begin
                in_value_next = 1'b0;
                count_next    = '0;
            end
        end
    end

    // Value tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg <= 1'b0;
            kind_reg     <= KIND_INT32;
            count_reg    <= '0;
        end else begin
            in_value_reg <= in_value_next;
            kind_reg     <= kind_next;
            count_reg    <= count_next;
        end
    end

endmodule

### rtl/vsd_queue.sv
module vsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  vsd_pkg::vsd_entry_t  push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output vsd_pkg::vsd_entry_t  pop_entry
);
    import vsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    vsd_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/vsd_back.sv
module vsd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  vsd_pkg::vsd_entry_t           pop_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vsd_pkg::VALUE_W-1:0]   m_value,
    output logic [1:0]                    m_kind,
    output logic                          m_error
);
    import vsd_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [1:0]         m_kind_reg, m_kind_next;
    logic               m_error_reg, m_error_next;

    logic               out_free;
    logic               pop;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_new;

    assign out_free  = !m_valid_reg || m_ready;
    // Gather-only requests never wait for the output register
    assign pop_ready = out_free || (pop_entry.op == OP_ACC);
    assign pop       = pop_valid && pop_ready;

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_kind  = m_kind_reg;
    assign m_error = m_error_reg;

    // Shift the payload into place and mask to the kind's width
    always_comb begin
        acc_base = (pop_entry.idx == '0) ? '0 : acc_reg;
        acc_new  = (acc_base | (VALUE_W'(pop_entry.payload) << byte_shift(pop_entry.idx)))
                   & kind_mask(pop_entry.kind);

        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_kind_next  = m_kind_reg;
        m_error_next = m_error_reg;
        if (pop) begin
            case (pop_entry.op)
                OP_ACC: begin
                    acc_next = acc_new;
                end
                OP_DONE: begin
                    acc_next     = '0;
                    m_valid_next = 1'b1;
                    m_value_next = acc_new;
                    m_kind_next  = pop_entry.kind;
                    m_error_next = 1'b0;
                end
                OP_ERR: begin
                    acc_next     = '0;
                    m_valid_next = 1'b1;
                    m_value_next = '0;
                    m_kind_next  = pop_entry.kind;
                    m_error_next = 1'b1;
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_kind_reg  <= m_kind_next;
        m_error_reg <= m_error_next;
    end

endmodule

### rtl/varint_stream_decoder_top.sv
// Path: a final byte is written into the queue storage, and its result is then registered
// in the output register that drives m_; a full output register holds it in the queue.
// Throughput: one byte per cycle while the queue has room; the shift/OR in the back end and
// the front's byte counter are combinational, and the queue absorbs output stalls until it fills.
// A result waits in the output register while bytes keep flowing into the queue.
// Reset (aresetn, synchronous, active low) empties the queue, clears the value
// in progress and drops any pending result.
module varint_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vsd_pkg::VALUE_W-1:0]   m_value,
    output logic [1:0]                    m_kind,
    output logic                          m_error
);
    import vsd_pkg::*;

    logic       push_valid, push_ready;
    vsd_entry_t push_entry;
    logic       pop_valid, pop_ready;
    vsd_entry_t pop_entry;

    vsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    vsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    vsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_kind    (m_kind),
        .m_error   (m_error)
    );

endmodule

### rtl/vsd_checker.sv
module vsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_value,
    input logic [1:0]  m_kind,
    input logic        m_error
);
    import vsd_pkg::*;

    // No result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_kind)
                                && $stable(m_error))
        else $error("stalled result changed");

    // An error result carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_value == 64'd0)
        else $error("error result with nonzero value");

    // Value fits the width of its kind, and the kind is a real one
    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_LONG64)
                 || (m_kind == KIND_INT32 && m_value[63:32] == 32'd0)
                 || (m_kind == KIND_SHORT16 && m_value[63:16] == 48'd0))
        else $error("value wider than its kind");

endmodule

bind varint_stream_decoder_top vsd_checker u_vsd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value),
    .m_kind  (m_kind),
    .m_error (m_error)
);

### sim/varint_result_checker.sv
`timescale 1ns / 1ps
module varint_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [7:0]                  s_data_byte,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [vsd_pkg::VALUE_W-1:0] m_value,
    input  logic [1:0]                  m_kind,
    input  logic                        m_error,
    output int                          fail_count,
    output int                          pending,
    output int                          results_checked
);
    import vsd_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         kind;
        logic               err;
    } varint_result_t;

    // decoded values still owed by the block, oldest first
    varint_result_t decoded_q[$];

    // shadow of the decoder's value in progress
    logic [VALUE_W-1:0] acc;
    logic [3:0]         byte_cnt;
    logic [1:0]         cur_kind;
    logic               in_value;

    task automatic report_field(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    // fold one request byte into the value in progress
    task automatic decode_byte(input logic [1:0] cmd, input logic [7:0] b);
        logic [3:0]         limit;
        logic [VALUE_W-1:0] mask;
        int                 shift;
        varint_result_t     r;
        if (!in_value) begin
            cur_kind = (cmd == KIND_UNUSED) ? KIND_INT32 : cmd;
            acc      = '0;
            byte_cnt = '0;
            in_value = 1'b1;
        end
        case (cur_kind)
            KIND_SHORT16: begin
                limit = 4'd3;
                mask  = 64'h0000_0000_0000_FFFF;
            end
            KIND_LONG64: begin
                limit = 4'd10;
                mask  = '1;
            end
            default: begin
                limit = 4'd5;
                mask  = 64'h0000_0000_FFFF_FFFF;
            end
        endcase
        shift = 7 * int'(byte_cnt);
        if (shift < VALUE_W)
            acc = acc | ({57'd0, b[6:0]} << shift);
        acc      = acc & mask;
        byte_cnt = byte_cnt + 4'd1;
        r.kind   = cur_kind;
        if (!b[7]) begin
            r.value = acc;
            r.err   = 1'b0;
            decoded_q.push_back(r);
            in_value = 1'b0;
        end else if (byte_cnt >= limit) begin
            // overlong: error result, value field zero
            r.value = '0;
            r.err   = 1'b1;
            decoded_q.push_back(r);
            in_value = 1'b0;
        end
    endtask

    always @(posedge aclk) begin : check_proc
        varint_result_t want;
        if (!aresetn) begin
            decoded_q.delete();
            acc             = '0;
            byte_cnt        = '0;
            cur_kind        = KIND_INT32;
            in_value        = 1'b0;
            fail_count      = 0;
            results_checked = 0;
        end else begin
            // results first: none can stem from a byte taken on this edge
            if (m_valid && m_ready) begin
                results_checked++;
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, %s %h kind %0d error %0b",
                             $time, "got value", m_value, m_kind, m_error);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_value !== want.value)
                        report_field("value", want.value, m_value);
                    if (m_kind !== want.kind)
                        report_field("kind", 64'(want.kind), 64'(m_kind));
                    if (m_error !== want.err)
                        report_field("error", 64'(want.err), 64'(m_error));
                end
            end
            if (s_valid && s_ready)
                decode_byte(s_cmd, s_data_byte);
        end
        pending <= decoded_q.size();
    end

endmodule

### sim/varint_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
module varint_stream_decoder_top_tb;
    import vsd_pkg::*;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd       = KIND_INT32;
    logic [7:0]         s_data_byte = 8'd0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [VALUE_W-1:0] m_value;
    logic [1:0]         m_kind;
    logic               m_error;

    // no idling on either side while set
    logic calm = 1'b0;

    int fail_count;
    int pending;
    int results_checked;
    int bytes_sent = 0;

    always #1 aclk = ~aclk;

    varint_stream_decoder_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_kind      (m_kind),
        .m_error     (m_error)
    );

    varint_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_kind          (m_kind),
        .m_error         (m_error),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // result side stalls at random
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 22);
    end

    // one request, with random idle cycles ahead of it
    task automatic send_byte(input logic [1:0] cmd, input logic [7:0] b);
        while (!calm && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // one encoded value; overlong keeps the continuation bit on every byte
    task automatic send_value(input logic [1:0] cmd, input int len, input bit overlong);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            case ($urandom_range(7))
                0: b[6:0] = 7'h7F;
                1: b[6:0] = 7'h00;
                default: ;
            endcase
            b[7] = overlong || (i < len - 1);
            // cmd is only looked at on the first byte
            send_byte((i == 0) ? cmd : 2'($urandom_range(3)), b);
        end
    endtask

    task automatic run_random(input int target);
        logic [1:0] cmd;
        int         max_len;
        int         pick;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            cmd  = ($urandom_range(9) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
            case (cmd)
                KIND_SHORT16: max_len = 3;
                KIND_LONG64:  max_len = 10;
                default:      max_len = 5;
            endcase
            if (pick < 80)
                send_value(cmd, $urandom_range(max_len, 1), 1'b0);
            else if (pick < 90)
                send_value(cmd, max_len, 1'b1);
            else
                send_byte(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    // hold the sender until every decoded value has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of each kind
        send_byte(KIND_INT32, 8'h00);
        send_byte(KIND_INT32, 8'h7F);
        // short16 with bits past 16 dropped
        send_byte(KIND_SHORT16, 8'hFF);
        send_byte(KIND_INT32, 8'hFF);
        send_byte(KIND_LONG64, 8'h7F);
        // long64 all ones over ten bytes
        for (int i = 0; i < 9; i++)
            send_byte(KIND_LONG64, 8'hFF);
        send_byte(KIND_SHORT16, 8'h01);
        // unused kind code falls back to int32
        send_byte(KIND_UNUSED, 8'h55);
        // overlong short16 and int32
        repeat (3) send_byte(KIND_SHORT16, 8'h80);
        repeat (5) send_byte(KIND_INT32, 8'hFF);

        // random, then a stretch with no idling, then a full drain
        run_random(700);
        calm <= 1'b1;
        run_random(1000);
        calm <= 1'b0;
        drain();
        run_random(1900);
        drain();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes over all kinds, the unused kind code, overlong values and noise;",
                 bytes_sent);
        $display("%0d decoded results compared.", results_checked);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/vsd_pkg.sv
rtl/vsd_front.sv
rtl/vsd_queue.sv
rtl/vsd_back.sv
rtl/varint_stream_decoder_top.sv
rtl/vsd_checker.sv
sim/varint_result_checker.sv
sim/varint_stream_decoder_top_tb.sv
